// ===== hw/rtl/ecmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecmc_pkg: shared types and constants
// Widths and defaults for the event-chain Monte Carlo step block.
// ----------------------------------------------------------------------------
package ecmc_pkg;
    localparam int RING_SIZE_DEFAULT = 1024;
    localparam logic [30:0] SAMPLE_TIME_RESET = 31'd67108864;
    localparam logic [15:0] TEMPERATURE_RESET = 16'd256;
    localparam logic [0:0] REG_SAMPLE_TIME = 1'b0;
    localparam logic [0:0] REG_TEMPERATURE = 1'b1;

    typedef struct packed {
        logic        start_run;
        logic [23:0] exp_right;
        logic [23:0] exp_left;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  active_site;
        logic [31:0] unwrapped_shift;
        logic [30:0] step_length;
        logic [31:0] active_position;
        logic [31:0] active_visits;
        logic [31:0] origin_visits;
        logic        run_done;
    } out_item_t;

    typedef struct packed {
        logic        index;
        logic [31:0] data;
    } cfg_item_t;
endpackage

// ===== hw/rtl/ecmc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecmc_if: valid/ready channel
// Generic handshake channel carrying one payload item.
// ----------------------------------------------------------------------------
interface ecmc_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/event_chain_monte_carlo_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_chain_monte_carlo_step: one event-chain step on a harmonic ring
// Sequencer around a shared square-root unit and two store RAMs.
// ----------------------------------------------------------------------------
// Each accepted item performs one event-chain move on a periodic ring of
// RING_SIZE harmonic particles. The two exponential variates are scaled by the
// temperature into energy budgets, each budget goes through the shared
// 32-step square-root unit, and the particle moves by the shorter of the two
// collision distances. The time per ordinary item is dominated by the two
// serial roots; the two energy builds and the reads and writes of the
// single-port position and visit RAMs, plus the idle state, make up the rest.
// A step that is trimmed back at the end of the time budget also passes
// through S_FIN, and an item that arrives after the run has finished skips
// the move and goes straight to the result. A start_run item, and the first
// item after reset, sweeps both RAMs to zero first, one entry per cycle. The
// result item is held in an output register until taken; the next item may
// be accepted meanwhile, and it only waits before it writes its own result
// into that register.
// ----------------------------------------------------------------------------
module event_chain_monte_carlo_step #(
    parameter int RING_SIZE = ecmc_pkg::RING_SIZE_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    ecmc_if.sink   in_ch,
    ecmc_if.sink   cfg_ch,
    ecmc_if.source out_ch
);
    import ecmc_pkg::*;

    localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam logic [AW-1:0] LAST = AW'(RING_SIZE - 1);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b00000000000000001,
        S_CLEAR  = 17'b00000000000000010,
        S_RDA    = 17'b00000000000000100,
        S_RDR    = 17'b00000000000001000,
        S_RDL    = 17'b00000000000010000,
        S_CAP    = 17'b00000000000100000,
        S_ENR    = 17'b00000000001000000,
        S_SQR    = 17'b00000000010000000,
        S_ENL    = 17'b00000000100000000,
        S_SQL    = 17'b00000001000000000,
        S_DEC    = 17'b00000010000000000,
        S_VRD    = 17'b00000100000000000,
        S_VWR    = 17'b00001000000000000,
        S_ORD    = 17'b00010000000000000,
        S_OWR    = 17'b00100000000000000,
        S_OUT    = 17'b01000000000000000,
        S_FIN    = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [30:0] sample_time_reg;
    logic [15:0] temperature_reg;
    logic        cleared_reg;
    logic [AW-1:0] ptr_reg, old_reg, nb_reg;
    logic [31:0] shift_reg;
    logic [31:0] elapsed_reg;
    logic        finished_reg;
    in_item_t    item_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0]  sub_reg;
    logic signed [31:0] xa_reg, xr_reg, xl_reg;
    logic [63:0] energy_reg;
    logic        sq_start;
    logic        sq_done;
    logic [31:0] sq_root;
    logic [63:0] rad;
    logic signed [33:0] rs_reg;
    logic [30:0] step_reg;
    logic        go_right_reg;
    logic        trim_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    // RAM ports
    logic          pos_we, vis_we;
    logic [AW-1:0] pos_addr, vis_addr;
    logic [31:0]   pos_wdata, vis_wdata, pos_rdata, vis_rdata;

    ecmc_ram #(.WIDTH(32), .DEPTH(RING_SIZE)) u_pos (
        .clk(clk), .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rdata)
    );
    ecmc_ram #(.WIDTH(32), .DEPTH(RING_SIZE)) u_vis (
        .clk(clk), .we(vis_we), .addr(vis_addr), .wdata(vis_wdata), .rdata(vis_rdata)
    );
    ecmc_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(rad),
        .done(sq_done), .root(sq_root)
    );

    // Neighbor indexes of the active pointer.
    logic [AW-1:0] right_idx, left_idx;
    assign right_idx = (ptr_reg == LAST) ? '0 : AW'(ptr_reg + 1'b1);
    assign left_idx  = (ptr_reg == '0) ? LAST : AW'(ptr_reg - 1'b1);

    // Separations (exact 33-bit differences).
    logic signed [32:0] sep_r, sep_l, sep_m;
    logic [32:0] sep_abs;
    logic        penal;
    assign sep_r = 33'(xr_reg) - 33'(xa_reg);
    assign sep_l = 33'(xa_reg) - 33'(xl_reg);
    assign sep_m = (state_reg == S_ENL) ? sep_l : sep_r;
    assign sep_abs = sep_m[32] ? 33'(-sep_m) : sep_m;
    assign penal = (state_reg == S_ENL) ? (sep_l > 0) : (sep_r < 0);

    // Energy build: sub_reg 0 = scaled variate, 1 = add penalty.
    logic [39:0] scaled;
    logic [65:0] sq_sep;
    logic [23:0] variate;
    logic [64:0] two;
    assign variate = (state_reg == S_ENL) ? item_reg.exp_left : item_reg.exp_right;
    assign scaled = 40'(temperature_reg) * 40'(variate);
    assign sq_sep = 66'(sep_abs) * 66'(sep_abs);
    assign two = {energy_reg, 1'b0};
    // Twice the energy saturates at 2^48 - 1 before it moves up into Q48.16.
    assign rad = (two > 65'h0FFFFFFFFFFFF) ? 64'hFFFF_FFFF_FFFF_0000
                                           : {two[47:0], 16'd0};

    logic signed [33:0] dist_raw;
    logic [30:0] coll_dist;
    assign dist_raw = (state_reg == S_SQL) ? 34'($signed({2'b00, sq_root})) - 34'(sep_l)
                                           : 34'($signed({2'b00, sq_root})) + 34'(sep_r);
    assign coll_dist = dist_raw[33] ? 31'd0 : (dist_raw > 34'sh7FFFFFFF ? 31'h7FFFFFFF
                                                                       : dist_raw[30:0]);

    logic [31:0] rem_val;
    logic signed [33:0] newpos;
    logic [31:0] newpos_sat;
    assign rem_val = ({1'b0, sample_time_reg} > elapsed_reg)
                     ? 32'({1'b0, sample_time_reg} - elapsed_reg) : 32'd0;
    assign newpos = 34'(xa_reg) + 34'({1'b0, step_reg});
    assign newpos_sat = (newpos > 34'sh7FFFFFFF) ? 32'h7FFFFFFF : newpos[31:0];

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_we = 1'b0; vis_we = 1'b0;
        pos_addr = ptr_reg; vis_addr = ptr_reg;
        pos_wdata = '0; vis_wdata = '0;
        sq_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = (in_ch.payload.start_run || !cleared_reg) ? S_CLEAR : S_RDA;
                end
            end
            S_CLEAR:
            begin
                pos_we = 1'b1; vis_we = 1'b1;
                pos_addr = clr_reg; vis_addr = clr_reg;
                if (clr_reg == LAST)
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                state_next = finished_reg ? S_ORD : S_RDR;
            end
            S_RDR: begin pos_addr = right_idx; state_next = S_RDL; end
            S_RDL: begin pos_addr = left_idx; state_next = S_CAP; end
            S_CAP: state_next = S_ENR;
            S_ENR:
            begin
                if (sub_reg == 2'd2)
                begin
                    sq_start = 1'b1; state_next = S_SQR;
                end
            end
            S_SQR: if (sq_done) state_next = S_ENL;
            S_ENL:
            begin
                if (sub_reg == 2'd2)
                begin
                    sq_start = 1'b1; state_next = S_SQL;
                end
            end
            S_SQL: if (sq_done) state_next = S_DEC;
            S_DEC:
            begin
                pos_we = 1'b1; pos_addr = old_reg; pos_wdata = newpos_sat;
                vis_addr = nb_reg;
                state_next = S_VRD;
            end
            S_VRD: begin vis_addr = nb_reg; state_next = S_VWR; end
            S_VWR:
            begin
                vis_we = 1'b1; vis_addr = nb_reg; vis_wdata = 32'(vis_rdata + 32'd1);
                state_next = trim_reg ? S_FIN : S_ORD;
            end
            S_FIN:
            begin
                // Trimmed step: the old site gives its visit back.
                if (sub_reg == 2'd0)
                begin
                    vis_addr = old_reg;
                end
                else
                begin
                    vis_we = 1'b1; vis_addr = old_reg; vis_wdata = 32'(vis_rdata - 32'd1);
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                // Wait here while the previous result item still sits in the
                // output register.
                vis_addr = '0;
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_OWR;
                end
            end
            S_OWR: begin state_next = S_OUT; end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_time_reg <= SAMPLE_TIME_RESET;
            temperature_reg <= TEMPERATURE_RESET;
            cleared_reg     <= 1'b0;
            ptr_reg         <= '0;
            shift_reg       <= '0;
            elapsed_reg     <= '0;
            finished_reg    <= 1'b0;
            clr_reg         <= '0;
            sub_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                if (cfg_ch.payload.index == REG_SAMPLE_TIME)
                    sample_time_reg <= cfg_ch.payload.data[30:0];
                else
                    temperature_reg <= cfg_ch.payload.data[15:0];
            end
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    clr_reg <= '0;
                    sub_reg <= '0;
                    if (in_ch.valid && in_ch.ready && in_ch.payload.start_run)
                    begin
                        ptr_reg <= '0; shift_reg <= '0; elapsed_reg <= '0;
                        finished_reg <= 1'b0;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= AW'(clr_reg + 1'b1);
                    if (clr_reg == LAST) cleared_reg <= 1'b1;
                end
                S_ENR, S_ENL:
                begin
                    sub_reg <= (sub_reg == 2'd2) ? 2'd0 : 2'(sub_reg + 2'd1);
                end
                S_VRD: sub_reg <= '0;
                S_FIN: sub_reg <= 2'd1;
                S_DEC:
                begin
                    if (!trim_reg)
                    begin
                        ptr_reg   <= nb_reg;
                        shift_reg <= go_right_reg ? 32'(shift_reg + 32'd1)
                                                  : 32'(shift_reg - 32'd1);
                        elapsed_reg <= 32'(elapsed_reg + 32'(step_reg));
                    end
                    else
                    begin
                        elapsed_reg  <= 32'(elapsed_reg + 32'(step_reg));
                        finished_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready) item_reg <= in_ch.payload;
                step_reg <= '0;
            end
            S_RDA: old_reg <= ptr_reg;
            S_RDR: xa_reg <= pos_rdata;
            S_RDL: xr_reg <= pos_rdata;
            S_CAP: xl_reg <= pos_rdata;
            S_ENR, S_ENL:
            begin
                if (sub_reg == 2'd0)
                    energy_reg <= 64'(scaled >> 8);
                else if (sub_reg == 2'd1 && penal)
                    energy_reg <= 64'(energy_reg + 64'(sq_sep >> 17));
            end
            S_SQR: if (sq_done) rs_reg <= 34'(coll_dist);
            S_SQL:
            begin
                if (sq_done)
                begin
                    go_right_reg <= (rs_reg[30:0] < coll_dist);
                    if (rs_reg[30:0] < coll_dist)
                    begin
                        nb_reg <= right_idx;
                        step_reg <= rs_reg[30:0];
                        trim_reg <= (33'(elapsed_reg) + 33'(rs_reg[30:0]))
                                    > 33'(sample_time_reg);
                        if ((33'(elapsed_reg) + 33'(rs_reg[30:0])) > 33'(sample_time_reg))
                            step_reg <= rem_val[30:0];
                    end
                    else
                    begin
                        nb_reg <= left_idx;
                        step_reg <= coll_dist;
                        trim_reg <= (33'(elapsed_reg) + 33'(coll_dist))
                                    > 33'(sample_time_reg);
                        if ((33'(elapsed_reg) + 33'(coll_dist)) > 33'(sample_time_reg))
                            step_reg <= rem_val[30:0];
                    end
                end
            end
            S_OWR:
            begin
                out_reg.origin_visits <= vis_rdata;
                out_reg.step_length   <= step_reg;
                out_reg.run_done      <= finished_reg;
                out_reg.unwrapped_shift <= shift_reg;
                out_reg.active_site   <= 10'(ptr_reg);
            end
            S_OUT:
            begin
                out_reg.active_position <= pos_rdata;
                out_reg.active_visits   <= vis_rdata;
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/ecmc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecmc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ecmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/ecmc_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecmc_sqrt: iterative integer square root
// Restoring square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module ecmc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [63:0] rad_reg, rad_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, rad_reg[63:62]};
        trial  = {32'd0, res_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            res_next  = '0;
            rad_next  = radicand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = 64'(rem_sh - trial);
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            cnt_next = 6'(cnt_reg + 6'd1);
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        rad_reg <= rad_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule
